// File: sv/sbgfe_pkg.sv
// Package for the seven-bit group frame encoder.
// Field widths, group constants and the result entry type; no dependencies.
`default_nettype none

package sbgfe_pkg;

  localparam int unsigned LEN_W           = 11;
  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned OUT_W           = 7;
  localparam int unsigned PRE_W           = 16;
  localparam int unsigned GROUP_LEN       = 7;
  localparam int unsigned MAX_RES         = 4;
  localparam int unsigned RES_IDX_W       = 2;
  localparam int unsigned RES_CNT_W       = 3;
  localparam int unsigned DEF_MAX_PAYLOAD = 1024;

  typedef struct packed {
    logic [OUT_W-1:0] out_byte;
    logic             is_flag;
    logic             run_last;
    logic             frame_end;
  } result_t;

endpackage

`default_nettype wire

// File: sv/seven_bit_group_frame_encoder_unit.sv
// Seven-bit group frame encoder, top level.
// Input register, single-pass encode logic and a four-entry result buffer.
// Depends on sbgfe_pkg.
// Input channel (in_valid_i / in_stall_o): one payload byte per transaction;
//   payload_len_i is used only on the first byte of a frame.
// Output channel (out_valid_o / out_stall_i): one encoded byte per transaction:
//   the two length prefix bytes, the data bytes and a flag byte after every
//   group of seven and after the final partial group.
// A transaction is taken at a rising edge with valid high and stall low.
// The accepted byte waits in the input register until the result buffer can
//   take it; it is then encoded and its results are written to the buffer.
// Throughput: each input byte yields 1 to 4 results and, while out_stall_i is
//   low, one result moves per cycle: 3 or 4 results for the first byte of a
//   frame, 2 when it closes a group or the frame, 1 otherwise. The next byte
//   is encoded in the cycle the last pending result is taken; bytes stream back to back.
// Reset: rst_ni clears the frame state and both valid flags; the first byte
//   after reset starts a new frame.
// Receiver stall: results hold in the buffer; once the input register is
//   full in_stall_o rises until the buffer drains.
`default_nettype none

module seven_bit_group_frame_encoder_unit
  import sbgfe_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = DEF_MAX_PAYLOAD
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [LEN_W-1:0]  payload_len_i,
  input  wire logic [BYTE_W-1:0] data_byte_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [OUT_W-1:0]       out_byte_o,
  output logic                   is_flag_o,
  output logic                   run_last_o,
  output logic                   frame_end_o
);

  localparam int unsigned LW   = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned CW   = (LW > LEN_W) ? LW : LEN_W;
  localparam int unsigned XW   = $clog2(MAX_PAYLOAD + 9);
  localparam int unsigned SH   = XW + 3;
  localparam int unsigned MW   = SH - 2;
  localparam int unsigned PRW  = XW + MW;
  localparam logic [MW-1:0] M_RECIP = MW'((2 ** SH + GROUP_LEN - 1) / GROUP_LEN);
  localparam logic [2:0]    GP_LAST  = 3'(GROUP_LEN - 1);
  localparam logic [2:0]    GP_FIRST = 3'd3;

  // input register
  logic              in_valid_q, in_valid_d;
  logic [LEN_W-1:0]  len_q;
  logic [BYTE_W-1:0] data_q;

  // frame state
  logic [LW-1:0]     bytes_left_q, bytes_left_d;
  logic [2:0]        group_pos_q, group_pos_d;
  logic [OUT_W-1:0]  top_bits_q, top_bits_d;

  // result buffer
  result_t              buf_q [MAX_RES];
  result_t              res   [MAX_RES];
  logic [RES_CNT_W-1:0] cnt_q, cnt_d, res_cnt;
  logic [RES_IDX_W-1:0] rd_q, rd_d;

  logic in_accept, out_take, load;

  // length prefix
  logic [CW-1:0]    len_ext, len_cl;
  logic [XW-1:0]    total, total_rnd, quot;
  logic [PRW-1:0]   prod;
  logic [XW:0]      enc;
  logic [PRE_W-1:0] pre;

  // per-byte work
  logic             first_byte, last_byte, full_grp;
  logic [OUT_W-1:0] tb_first, tb_next;

  assign out_valid_o = (cnt_q != '0);
  assign out_take    = out_valid_o && !out_stall_i;
  assign load        = in_valid_q &&
                       ((cnt_q == '0) || ((cnt_q == RES_CNT_W'(1)) && out_take));
  assign in_stall_o  = in_valid_q && !load;
  assign in_accept   = in_valid_i && !in_stall_o;

  assign out_byte_o  = buf_q[rd_q].out_byte;
  assign is_flag_o   = buf_q[rd_q].is_flag;
  assign run_last_o  = buf_q[rd_q].run_last;
  assign frame_end_o = buf_q[rd_q].frame_end;

  // encoded length = total + ceil(total / 7), via reciprocal multiply
  always_comb begin
    len_ext = CW'(len_q);
    if (len_ext == '0) begin
      len_cl = CW'(1);
    end else if (len_ext > CW'(MAX_PAYLOAD)) begin
      len_cl = CW'(MAX_PAYLOAD);
    end else begin
      len_cl = len_ext;
    end
    total     = XW'(len_cl) + XW'(2);
    total_rnd = total + XW'(GROUP_LEN - 1);
    prod      = PRW'(total_rnd) * PRW'(M_RECIP);
    quot      = XW'(prod >> SH);
    enc       = {1'b0, total} + {1'b0, quot};
    pre       = PRE_W'(enc) - PRE_W'(2);
  end

  always_comb begin
    first_byte = (bytes_left_q == '0);
    last_byte  = first_byte ? (len_cl == CW'(1)) : (bytes_left_q == LW'(1));
    full_grp   = (group_pos_q == GP_LAST);
    tb_first   = {4'b0, data_q[BYTE_W-1], pre[PRE_W-1], pre[BYTE_W-1]};
    tb_next    = top_bits_q | (OUT_W'(data_q[BYTE_W-1]) << group_pos_q);

    for (int i = 0; i < MAX_RES; i++) begin
      res[i] = '0;
    end

    if (first_byte) begin
      res[0].out_byte  = pre[OUT_W-1:0];
      res[1].out_byte  = pre[BYTE_W +: OUT_W];
      res[2].out_byte  = data_q[OUT_W-1:0];
      res[3].out_byte  = tb_first;
      res[3].is_flag   = 1'b1;
      res[3].run_last  = 1'b1;
      res[3].frame_end = 1'b1;
      res[2].run_last  = !last_byte;
      res_cnt          = last_byte ? RES_CNT_W'(4) : RES_CNT_W'(3);
      bytes_left_d     = LW'(len_cl) - LW'(1);
      group_pos_d      = last_byte ? 3'd0 : GP_FIRST;
      top_bits_d       = last_byte ? '0 : tb_first;
    end else begin
      res[0].out_byte  = data_q[OUT_W-1:0];
      res[0].run_last  = !(full_grp || last_byte);
      res[1].out_byte  = tb_next;
      res[1].is_flag   = 1'b1;
      res[1].run_last  = 1'b1;
      res[1].frame_end = last_byte;
      res_cnt          = (full_grp || last_byte) ? RES_CNT_W'(2) : RES_CNT_W'(1);
      bytes_left_d     = bytes_left_q - LW'(1);
      group_pos_d      = (full_grp || last_byte) ? 3'd0 : group_pos_q + 3'd1;
      top_bits_d       = (full_grp || last_byte) ? '0 : tb_next;
    end
  end

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (load) begin
      in_valid_d = 1'b0;
    end
    cnt_d = cnt_q;
    rd_d  = rd_q;
    if (load) begin
      cnt_d = res_cnt;
      rd_d  = '0;
    end else if (out_take) begin
      cnt_d = cnt_q - RES_CNT_W'(1);
      rd_d  = rd_q + RES_IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      cnt_q        <= '0;
      rd_q         <= '0;
      bytes_left_q <= '0;
      group_pos_q  <= '0;
      top_bits_q   <= '0;
    end else begin
      in_valid_q <= in_valid_d;
      cnt_q      <= cnt_d;
      rd_q       <= rd_d;
      if (load) begin
        bytes_left_q <= bytes_left_d;
        group_pos_q  <= group_pos_d;
        top_bits_q   <= top_bits_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      len_q  <= payload_len_i;
      data_q <= data_byte_i;
    end
    if (load) begin
      for (int i = 0; i < MAX_RES; i++) begin
        buf_q[i] <= res[i];
      end
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= RES_CNT_W'(MAX_RES))
    else $error("result count out of range");

  a_frame_end_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_end_o |-> is_flag_o && run_last_o)
    else $error("frame end not on a closing flag byte");

  a_more_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !run_last_o |-> cnt_q > RES_CNT_W'(1))
    else $error("non-final result without successor in buffer");

  a_load_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> out_valid_o && rd_q == '0)
    else $error("load left the buffer empty");
`endif

endmodule

`default_nettype wire

// File: tb/seven_bit_group_frame_encoder_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for seven_bit_group_frame_encoder_unit.
// Directed table plus random frames, checked by a behavioral encoder model.
// Depends on sbgfe_pkg and the encoder top level.

module seven_bit_group_frame_encoder_unit_tb
  import sbgfe_pkg::*;
;

  localparam int unsigned RAND_BYTES  = 360;
  localparam int unsigned LIMIT       = 1000000;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned REPORT_MAX  = 10;
  localparam int unsigned TAIL_CYCLES = 10;
  localparam int unsigned MAX_LEN     = DEF_MAX_PAYLOAD;

  typedef struct packed {
    logic [LEN_W-1:0]      len;
    logic [BYTE_W-1:0]     data;
    logic [RES_CNT_W-1:0]  n_typed;
    result_t [MAX_RES-1:0] typed;
  } stim_row_t;

  localparam result_t NO_RES = '0;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [LEN_W-1:0]  payload_len_i;
  logic [BYTE_W-1:0] data_byte_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [OUT_W-1:0]  out_byte_o;
  logic              is_flag_o;
  logic              run_last_o;
  logic              frame_end_o;

  // encoder model state
  int unsigned      frame_left;
  logic [2:0]       group_pos;
  logic [OUT_W-1:0] group_bits;
  result_t          step_res [MAX_RES];
  int unsigned      step_n;
  result_t          enc_expect_q [$];

  bit          tx_quiet;
  bit          rx_quiet;
  bit          hold_req;
  int unsigned cycle_cnt    = 0;
  int unsigned err_cnt      = 0;
  int unsigned n_bytes      = 0;
  int unsigned n_frames     = 0;
  int unsigned n_checked    = 0;
  int unsigned n_flag_bytes = 0;
  int unsigned n_holds      = 0;

  seven_bit_group_frame_encoder_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .payload_len_i (payload_len_i),
    .data_byte_i   (data_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .is_flag_o     (is_flag_o),
    .run_last_o    (run_last_o),
    .frame_end_o   (frame_end_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic result_t res(logic [OUT_W-1:0] b, logic f, logic l, logic e);
    res = '{out_byte: b, is_flag: f, run_last: l, frame_end: e};
  endfunction

  function automatic stim_row_t row_of(logic [LEN_W-1:0] len, logic [BYTE_W-1:0] data,
                                       logic [RES_CNT_W-1:0] n, result_t r0, result_t r1,
                                       result_t r2, result_t r3);
    stim_row_t r;
    r.len      = len;
    r.data     = data;
    r.n_typed  = n;
    r.typed[0] = r0;
    r.typed[1] = r1;
    r.typed[2] = r2;
    r.typed[3] = r3;
    return r;
  endfunction

  function automatic void emit(logic [OUT_W-1:0] b, logic flag);
    step_res[step_n] = res(b, flag, 1'b0, 1'b0);
    step_n++;
  endfunction

  function automatic void emit_flag();
    emit(group_bits, 1'b1);
    group_pos  = '0;
    group_bits = '0;
  endfunction

  function automatic void emit_data(logic [BYTE_W-1:0] b);
    emit(b[OUT_W-1:0], 1'b0);
    group_bits[group_pos] = b[BYTE_W-1];
    group_pos++;
    if (group_pos == GROUP_LEN) emit_flag();
  endfunction

  // Encoded bytes caused by one accepted payload byte; fills step_res.
  function automatic void encode_byte(logic [LEN_W-1:0] len_f, logic [BYTE_W-1:0] data);
    int unsigned      ln;
    int unsigned      total;
    int unsigned      enc;
    logic [PRE_W-1:0] pre;
    step_n = 0;
    if (frame_left == 0) begin
      ln = len_f;
      if (ln < 1) ln = 1;
      if (ln > MAX_LEN) ln = MAX_LEN;
      total = ln + 2;
      enc   = total + (total + GROUP_LEN - 1) / GROUP_LEN;
      pre   = PRE_W'(enc - 2);
      group_pos  = '0;
      group_bits = '0;
      emit_data(pre[7:0]);
      emit_data(pre[15:8]);
      frame_left = ln;
      n_frames++;
    end
    emit_data(data);
    frame_left--;
    if (frame_left == 0 && group_pos != 0) emit_flag();
    step_res[step_n-1].run_last = 1'b1;
    if (frame_left == 0) step_res[step_n-1].frame_end = 1'b1;
  endfunction

  function automatic int unsigned pick_gap(bit quiet);
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 6);
    return $urandom_range(10, 30);
  endfunction

  task automatic send_byte(logic [LEN_W-1:0] len_f, logic [BYTE_W-1:0] data,
                           logic [RES_CNT_W-1:0] n_typed, result_t [MAX_RES-1:0] typed);
    int unsigned gap;
    gap = pick_gap(tx_quiet);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    payload_len_i <= len_f;
    data_byte_i   <= data;
    do @(posedge clk_i); while (in_stall_o);
    encode_byte(len_f, data);
    n_bytes++;
    if (n_typed != 0) begin
      for (int i = 0; i < n_typed; i++) enc_expect_q.push_back(typed[i]);
    end else begin
      for (int i = 0; i < step_n; i++) enc_expect_q.push_back(step_res[i]);
    end
  endtask

  // receiver: random stall runs, plus long hold-offs on request
  initial begin
    int unsigned n;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        n_holds++;
        repeat (HOLD_CYCLES) begin
          @(negedge clk_i);
          out_stall_i <= 1'b1;
        end
      end else begin
        n = pick_gap(rx_quiet);
        repeat (n) begin
          @(negedge clk_i);
          out_stall_i <= 1'b1;
        end
      end
      @(negedge clk_i);
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin : check_out
    result_t got;
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = res(out_byte_o, is_flag_o, run_last_o, frame_end_o);
      n_checked++;
      if (got.is_flag) n_flag_bytes++;
      if (enc_expect_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= REPORT_MAX)
          $display("%0t: unexpected transaction byte %h flag %b last %b end %b",
                   $time, got.out_byte, got.is_flag, got.run_last, got.frame_end);
      end else begin
        want = enc_expect_q.pop_front();
        if (got.out_byte !== want.out_byte || got.is_flag !== want.is_flag ||
            got.run_last !== want.run_last || got.frame_end !== want.frame_end) begin
          err_cnt++;
          if (err_cnt <= REPORT_MAX)
            $display("%0t: mismatch exp byte %h flag %b last %b end %b, got %h %b %b %b",
                     $time, want.out_byte, want.is_flag, want.run_last, want.frame_end,
                     got.out_byte, got.is_flag, got.run_last, got.frame_end);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, enc_expect_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    stim_row_t        dir_tab [$];
    stim_row_t        clamp_row;
    int unsigned      rand_sent;
    int unsigned      r;
    logic [LEN_W-1:0] len_f;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    payload_len_i = '0;
    data_byte_i   = '0;
    frame_left    = 0;
    group_pos     = '0;
    group_bits    = '0;
    tx_quiet      = 1'b0;
    rx_quiet      = 1'b0;
    hold_req      = 1'b0;

    // single-byte frames: prefix, data and closing flag
    dir_tab.push_back(row_of(11'd1, 8'hFF, RES_CNT_W'(4),
                             res(7'h02, 1'b0, 1'b0, 1'b0), res(7'h00, 1'b0, 1'b0, 1'b0),
                             res(7'h7F, 1'b0, 1'b0, 1'b0), res(7'h04, 1'b1, 1'b1, 1'b1)));
    // zero length is taken as one
    dir_tab.push_back(row_of(11'd0, 8'h00, RES_CNT_W'(4),
                             res(7'h02, 1'b0, 1'b0, 1'b0), res(7'h00, 1'b0, 1'b0, 1'b0),
                             res(7'h00, 1'b0, 1'b0, 1'b0), res(7'h00, 1'b1, 1'b1, 1'b1)));
    // total of seven: the full-group flag closes the frame
    dir_tab.push_back(row_of(11'd5,   8'h80, '0, NO_RES, NO_RES, NO_RES, NO_RES));
    dir_tab.push_back(row_of(11'h7FF, 8'h01, '0, NO_RES, NO_RES, NO_RES, NO_RES));
    dir_tab.push_back(row_of(11'h000, 8'h7F, '0, NO_RES, NO_RES, NO_RES, NO_RES));
    dir_tab.push_back(row_of(11'h2AA, 8'hFF, '0, NO_RES, NO_RES, NO_RES, NO_RES));
    dir_tab.push_back(row_of(11'h555, 8'h00, '0, NO_RES, NO_RES, NO_RES, NO_RES));
    // full group then a one-byte partial group
    dir_tab.push_back(row_of(11'd6, 8'hFF, '0, NO_RES, NO_RES, NO_RES, NO_RES));
    dir_tab.push_back(row_of(11'd1, 8'hFF, '0, NO_RES, NO_RES, NO_RES, NO_RES));
    dir_tab.push_back(row_of(11'd1, 8'hFF, '0, NO_RES, NO_RES, NO_RES, NO_RES));
    dir_tab.push_back(row_of(11'd1, 8'hFF, '0, NO_RES, NO_RES, NO_RES, NO_RES));
    dir_tab.push_back(row_of(11'd1, 8'hFF, '0, NO_RES, NO_RES, NO_RES, NO_RES));
    dir_tab.push_back(row_of(11'd1, 8'hFF, '0, NO_RES, NO_RES, NO_RES, NO_RES));
    dir_tab.push_back(row_of(11'd3, 8'h7F, '0, NO_RES, NO_RES, NO_RES, NO_RES));
    dir_tab.push_back(row_of(11'd3, 8'h80, '0, NO_RES, NO_RES, NO_RES, NO_RES));
    dir_tab.push_back(row_of(11'd3, 8'hFE, '0, NO_RES, NO_RES, NO_RES, NO_RES));
    dir_tab.push_back(row_of(11'd2, 8'h00, '0, NO_RES, NO_RES, NO_RES, NO_RES));
    dir_tab.push_back(row_of(11'h7FF, 8'h80, '0, NO_RES, NO_RES, NO_RES, NO_RES));
    // oversize length is clamped to the maximum payload; sent last, frame left open
    clamp_row = row_of(11'h7FF, 8'hFF, RES_CNT_W'(3),
                       res(7'h13, 1'b0, 1'b0, 1'b0), res(7'h04, 1'b0, 1'b0, 1'b0),
                       res(7'h7F, 1'b0, 1'b1, 1'b0), NO_RES);

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_tab[i])
      send_byte(dir_tab[i].len, dir_tab[i].data, dir_tab[i].n_typed, dir_tab[i].typed);
    while (frame_left != 0)
      send_byte(LEN_W'($urandom_range(0, 2047)), BYTE_W'($urandom_range(0, 255)), '0, '0);

    hold_req  = 1'b1;
    rand_sent = 0;
    while (rand_sent < RAND_BYTES || frame_left != 0) begin
      if (rand_sent % 50 == 0) begin
        tx_quiet = ($urandom_range(0, 3) == 0);
        rx_quiet = ($urandom_range(0, 3) == 0);
      end
      if (rand_sent == RAND_BYTES / 2) hold_req = 1'b1;
      if (frame_left == 0) begin
        r = $urandom_range(0, 99);
        if (r < 70) len_f = LEN_W'($urandom_range(1, 14));
        else if (r < 92) len_f = LEN_W'($urandom_range(15, 48));
        else if (r < 96) len_f = '0;
        else len_f = LEN_W'($urandom_range(49, 120));
      end else begin
        len_f = LEN_W'($urandom_range(0, 2047));
      end
      send_byte(len_f, BYTE_W'($urandom_range(0, 255)), '0, '0);
      rand_sent++;
    end

    send_byte(clamp_row.len, clamp_row.data, clamp_row.n_typed, clamp_row.typed);
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    while (enc_expect_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Encoded %0d payload bytes in %0d frames, the last opened with a clamped length.",
             n_bytes, n_frames);
    $display("Checked %0d output bytes (%0d flags), %0d receiver hold-offs, %0d mismatches.",
             n_checked, n_flag_bytes, n_holds, err_cnt);
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
